// ===== rtl/sise_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sise_pkg
// Shared types, codes and helpers of the sorted integer set engine.
// ----------------------------------------------------------------------------
package sise_pkg;

    // Stored key width and default set depth
    localparam int KEY_W     = 64;
    localparam int DEPTH_DEF = 64;

    // Sign flip so unsigned key order equals signed value order
    localparam logic [KEY_W-1:0] SIGN_BIAS = {1'b1, {(KEY_W-1){1'b0}}};

    // Operation codes carried in tuser
    localparam logic [1:0] FUNC_INS = 2'd0;
    localparam logic [1:0] FUNC_REM = 2'd1;
    localparam logic [1:0] FUNC_QRY = 2'd2;

    // Storage encoding codes
    localparam logic [1:0] ENC16 = 2'd0;
    localparam logic [1:0] ENC32 = 2'd1;
    localparam logic [1:0] ENC64 = 2'd2;

    // Mode of the operation wave travelling down the cell row
    typedef enum logic [5:0] {
        MODE_INS   = 6'b000001,  // looking for the insert slot
        MODE_CARRY = 6'b000010,  // pushing displaced keys up the row
        MODE_FIND  = 6'b000100,  // lookup only, no change
        MODE_REM   = 6'b001000,  // looking for the key to drop
        MODE_DEL   = 6'b010000,  // pulling keys down the row
        MODE_PASS  = 6'b100000   // settled, outcome rides along
    } mode_t;

    // Payload of one wave stage
    typedef struct packed {
        mode_t            mode;
        logic [KEY_W-1:0] key;
        logic             ok;
    } wave_t;

    // One result word
    typedef struct packed {
        logic [1:0] width_code;
        logic [6:0] count;
        logic       full_res;
        logic       ok;
    } res_t;

    // Narrowest encoding that holds a signed value (INT16 / INT32 ranges)
    function automatic logic [1:0] need_width(input logic [KEY_W-1:0] v);
        logic fits16;
        logic fits32;
        fits16 = (v[KEY_W-1:15] == '0) || (v[KEY_W-1:15] == '1);
        fits32 = (v[KEY_W-1:31] == '0) || (v[KEY_W-1:31] == '1);
        if (fits16)
            return ENC16;
        else if (fits32)
            return ENC32;
        else
            return ENC64;
    endfunction

endpackage

// ===== rtl/sise_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sise_cell
// One slot of the sorted row: holds a key and steps the operation wave.
// ----------------------------------------------------------------------------
module sise_cell
    import sise_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] cnt,       // entries held, stable during a wave
    input  logic             wave_vld_in,
    input  wave_t            wave_in,
    input  logic [KEY_W-1:0] nxt_key,   // key of the next cell up
    output logic             wave_vld_out,
    output wave_t            wave_out,
    output logic [KEY_W-1:0] key
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             vld_reg;
    wave_t            wave_reg;
    wave_t            wave_next;
    logic             occ;
    logic             is_eq;
    logic             is_gt;

    // Slot occupancy and compare against the wave key
    assign occ   = IDX_C < cnt;
    assign is_eq = key_reg == wave_in.key;
    assign is_gt = key_reg > wave_in.key;

    // Wave step
    always_comb
    begin
        key_next  = key_reg;
        wave_next = wave_in;
        case (wave_in.mode)
            MODE_INS:
            begin
                if (!occ)
                begin
                    key_next       = wave_in.key;
                    wave_next.mode = MODE_PASS;
                    wave_next.ok   = 1'b1;
                end
                else if (is_eq)
                begin
                    wave_next.mode = MODE_PASS;
                end
                else if (is_gt)
                begin
                    key_next       = wave_in.key;
                    wave_next.key  = key_reg;
                    wave_next.mode = MODE_CARRY;
                    wave_next.ok   = 1'b1;
                end
            end
            MODE_CARRY:
            begin
                key_next = wave_in.key;
                if (!occ)
                    wave_next.mode = MODE_PASS;
                else
                    wave_next.key = key_reg;
            end
            MODE_FIND:
            begin
                if (!occ || is_gt)
                    wave_next.mode = MODE_PASS;
                else if (is_eq)
                begin
                    wave_next.mode = MODE_PASS;
                    wave_next.ok   = 1'b1;
                end
            end
            MODE_REM:
            begin
                if (!occ || is_gt)
                    wave_next.mode = MODE_PASS;
                else if (is_eq)
                begin
                    key_next       = nxt_key;
                    wave_next.mode = MODE_DEL;
                    wave_next.ok   = 1'b1;
                end
            end
            MODE_DEL:
            begin
                key_next = nxt_key;
            end
            MODE_PASS:
            begin
                wave_next = wave_in;
            end
            default:
            begin
                wave_next.mode = MODE_PASS;
            end
        endcase
        if (!wave_vld_in)
            key_next = key_reg;
    end

    // Stored key and wave payload, no reset
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        wave_reg <= wave_next;
    end

    // Wave valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= wave_vld_in;
    end

    assign wave_vld_out = vld_reg;
    assign wave_out     = wave_reg;
    assign key          = key_reg;

endmodule

// ===== rtl/sorted_int_set_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_int_set_engine
// Sorted set of distinct signed 64-bit integers held in a row of cells.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                    Contents
// s_*      in   s_tvalid s_tready s_tdata  tdata: value[63:0]; tuser: func[1:0]
// m_*      out  m_tvalid m_tready m_tdata  ok, full_res, count, width_code
//
// Each word starts a wave that walks the cell row one cell per cycle; a new word
// is taken only once that wave has left the row and busy_reg has cleared.
// The result is registered when the wave leaves the row.
// Reset empties the set and selects the 16-bit encoding; no clearing pass.
// A result that finishes while m_tready stalls the output sits in a spare register;
// no new word is taken until it has moved to the output register.
// ----------------------------------------------------------------------------
module sorted_int_set_engine
    import sise_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value[63:0]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // ok[0], full_res[1], count[8:2], width_code[10:9]
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    // Wave chain and key taps
    logic             wv_vld [DEPTH+1];
    wave_t            wv     [DEPTH+1];
    logic [KEY_W-1:0] keys   [DEPTH];

    logic             busy_reg;
    logic             inj_vld_reg;
    wave_t            inj_reg;
    logic             op_ins_reg;
    logic             op_rem_reg;
    logic             full_ins_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [1:0]       enc_reg;
    logic             m_vld_reg;
    res_t             m_res_reg;
    logic             pend_vld_reg;
    res_t             pend_reg;

    logic             s_acc;
    logic [1:0]       need;
    logic             is_full;
    wave_t            inj_next;
    logic             wave_end;
    logic             fin_ok;
    logic             fin_full;
    logic [CNT_W+6:0] cnt_ext;
    res_t             res;
    logic             out_free;

    assign s_tready = !busy_reg && !pend_vld_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign need     = need_width(s_tdata);
    assign is_full  = cnt_reg == DEPTH_C;

    // Wave launched for an accepted word
    always_comb
    begin
        inj_next.key = s_tdata ^ SIGN_BIAS;
        inj_next.ok  = 1'b0;
        case (s_tuser)
            FUNC_INS: inj_next.mode = is_full ? MODE_FIND : MODE_INS;
            FUNC_REM: inj_next.mode = (need <= enc_reg) ? MODE_REM : MODE_PASS;
            FUNC_QRY: inj_next.mode = (need <= enc_reg) ? MODE_FIND : MODE_PASS;
            default:  inj_next.mode = MODE_PASS;
        endcase
    end

    // Cell row
    assign wv_vld[0] = inj_vld_reg;
    assign wv[0]     = inj_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0] nxt;
        if (i == DEPTH - 1)
        begin : g_top
            assign nxt = keys[i];
        end
        else
        begin : g_mid
            assign nxt = keys[i+1];
        end

        sise_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .cnt          (cnt_reg),
            .wave_vld_in  (wv_vld[i]),
            .wave_in      (wv[i]),
            .nxt_key      (nxt),
            .wave_vld_out (wv_vld[i+1]),
            .wave_out     (wv[i+1]),
            .key          (keys[i])
        );
    end

    // Outcome when the wave leaves the row
    assign wave_end = wv_vld[DEPTH];
    assign fin_ok   = wv[DEPTH].ok && !full_ins_reg;
    assign fin_full = full_ins_reg && !wv[DEPTH].ok;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (op_ins_reg && fin_ok)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (op_rem_reg && fin_ok)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    assign cnt_ext        = {7'd0, cnt_next};
    assign res.ok         = fin_ok;
    assign res.full_res   = fin_full;
    assign res.count      = cnt_ext[6:0];
    assign res.width_code = enc_reg;

    assign out_free = !m_vld_reg || m_tready;

    // Launch register payload
    always_ff @(posedge clk)
    begin
        if (s_acc)
            inj_reg <= inj_next;
    end

    // Control, set state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            inj_vld_reg  <= 1'b0;
            op_ins_reg   <= 1'b0;
            op_rem_reg   <= 1'b0;
            full_ins_reg <= 1'b0;
            cnt_reg      <= '0;
            enc_reg      <= ENC16;
            m_vld_reg    <= 1'b0;
            m_res_reg    <= '0;
            pend_vld_reg <= 1'b0;
            pend_reg     <= '0;
        end
        else
        begin
            inj_vld_reg <= s_acc;
            if (s_acc)
            begin
                busy_reg     <= 1'b1;
                op_ins_reg   <= (s_tuser == FUNC_INS) && !is_full;
                op_rem_reg   <= s_tuser == FUNC_REM;
                full_ins_reg <= (s_tuser == FUNC_INS) && is_full;
                if ((s_tuser == FUNC_INS) && (need > enc_reg))
                    enc_reg <= need;
            end
            else if (wave_end)
            begin
                busy_reg <= 1'b0;
                cnt_reg  <= cnt_next;
            end

            // Output register with one spare slot
            if (wave_end)
            begin
                if (out_free)
                begin
                    m_vld_reg <= 1'b1;
                    m_res_reg <= res;
                end
                else
                begin
                    pend_vld_reg <= 1'b1;
                    pend_reg     <= res;
                end
            end
            else if (pend_vld_reg && out_free)
            begin
                m_vld_reg    <= 1'b1;
                m_res_reg    <= pend_reg;
                pend_vld_reg <= 1'b0;
            end
            else if (out_free)
            begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {5'd0, m_res_reg};

    // No wave can leave the row unless one was launched
    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wave_end |-> busy_reg)
        else $error("wave left the row with no word in flight");

    // A spare result implies the output register is held
    a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> m_vld_reg)
        else $error("spare result without output result");

    // Entry count stays within the row
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("entry count beyond depth");

    // Encoding never narrows
    a_enc_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> enc_reg >= $past(enc_reg))
        else $error("encoding narrowed");

    // Count only moves when a wave completes
    a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !wave_end |=> cnt_reg == $past(cnt_reg))
        else $error("count changed without a finished wave");

endmodule
